// ----- hdl/tptc_pkg.sv -----
`default_nettype none

package tptc_pkg;

	localparam int LIST_DEPTH_DEF = 64;
	localparam int DUR_W          = 32;
	localparam int HALF_W         = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	// request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_HOLD    = 2'd2;

	typedef struct packed {
		logic              init_level;
		logic [HALF_W-1:0] half;
		logic [DUR_W-1:0]  last_hold;
	} cfg_t;

	typedef struct packed {
		logic pin;
		logic busy;
		logic done;
		logic ovf;
	} res_t;

	// address bits for a store of the given depth
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tptc_ifs.sv -----
`default_nettype none

interface tptc_in_if;
	import tptc_pkg::*;

	logic             valid;
	logic             ready;
	logic             req_type;
	logic [DUR_W-1:0] duration_us;
	logic             last_entry;

	modport source(output valid, req_type, duration_us, last_entry, input ready);
	modport sink(input valid, req_type, duration_us, last_entry, output ready);
endinterface

interface tptc_out_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic busy_res;
	logic done_res;
	logic overflow;

	modport source(output valid, pin_level, busy_res, done_res, overflow, input ready);
	modport sink(input valid, pin_level, busy_res, done_res, overflow, output ready);
endinterface

`default_nettype wire

// ----- hdl/tptc_store.sv -----
`default_nettype none

module tptc_store #(
	parameter int LIST_DEPTH = tptc_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [tptc_pkg::addr_w(LIST_DEPTH)-1:0]   waddr,
	input  wire logic [tptc_pkg::DUR_W-1:0]                wdata,
	input  wire logic                                      re,
	input  wire logic [tptc_pkg::addr_w(LIST_DEPTH)-1:0]   raddr,
	output logic      [tptc_pkg::DUR_W-1:0]                rdata
);
	import tptc_pkg::*;

	logic [DUR_W-1:0] mem [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tptc_play.sv -----
`default_nettype none

module tptc_play #(
	parameter int LIST_DEPTH = tptc_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire tptc_pkg::cfg_t                          cfg,
	input  wire logic                                    in_accept,
	input  wire logic                                    req_type,
	input  wire logic [tptc_pkg::DUR_W-1:0]              duration_us,
	input  wire logic                                    last_entry,
	output logic                                         idle,
	output tptc_pkg::res_t                               res,
	output logic                                         emit,
	output logic                                         mem_we,
	output logic [tptc_pkg::addr_w(LIST_DEPTH)-1:0]      mem_waddr,
	output logic [tptc_pkg::DUR_W-1:0]                   mem_wdata,
	output logic                                         mem_re,
	output logic [tptc_pkg::addr_w(LIST_DEPTH)-1:0]      mem_raddr,
	input  wire logic [tptc_pkg::DUR_W-1:0]              mem_rdata
);
	import tptc_pkg::*;

	localparam int PTR_W = $clog2(LIST_DEPTH + 1);
	localparam int AW    = addr_w(LIST_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_ADV, S_LOAD, S_STEP} state_t;
	typedef enum logic [1:0] {PH_IDLE, PH_LIST, PH_HOLD} phase_t;

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic              list_ready_q, list_ready_d;
	logic [PTR_W-1:0]  wp_q, wp_d;
	logic [PTR_W-1:0]  rp_q, rp_d;
	logic              level_q, level_d;
	logic              seg_q, seg_d;
	logic              carried_q, carried_d;
	logic [HALF_W-1:0] half_q, half_d;
	logic [DUR_W-1:0]  rem_q, rem_d;
	logic [DUR_W-1:0]  budget_q, budget_d;
	logic              start_q, start_d;
	logic              pin_q, pin_d;
	logic              busy_q, busy_d;

	// interval loader: duration from the store or the hold register
	logic [DUR_W-1:0] ld_dur;
	logic [DUR_W:0]   ld_diff;
	logic             ld_car;
	logic             ld_ok;
	logic [DUR_W-1:0] ld_rem;
	logic [DUR_W-1:0] ld_budget;
	logic             ld_level;

	always_comb begin
		ld_dur  = (state_q == S_LOAD) ? mem_rdata : cfg.last_hold;
		ld_diff = {1'b0, ld_dur} - {{(DUR_W + 1 - HALF_W){1'b0}}, cfg.half};
		ld_car  = seg_q && (cfg.half != '0);
		if (ld_car) begin
			ld_ok     = !ld_diff[DUR_W];
			ld_rem    = {{(DUR_W - HALF_W){1'b0}}, cfg.half};
			ld_budget = ld_diff[DUR_W-1:0];
			ld_level  = 1'b1;
		end else begin
			ld_ok     = (ld_dur != '0);
			ld_rem    = ld_dur;
			ld_budget = '0;
			ld_level  = seg_q;
		end
	end

	// carrier budget: a new pair starts only while budget >= half period
	logic [DUR_W:0] st_diff;
	logic           st_ge;
	logic           rem_last;
	logic           run_step;

	assign st_diff  = {1'b0, budget_q} - {{(DUR_W + 1 - HALF_W){1'b0}}, half_q};
	assign st_ge    = !st_diff[DUR_W];
	assign rem_last = (rem_q[DUR_W-1:1] == '0);
	assign run_step = (state_q == S_STEP) ||
		(state_q == S_IDLE && in_accept && req_type == REQ_TICK && phase_q != PH_IDLE);

	assign idle      = (state_q == S_IDLE);
	assign mem_waddr = wp_q[AW-1:0];
	assign mem_raddr = rp_q[AW-1:0];
	assign mem_wdata = duration_us;

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		list_ready_d = list_ready_q;
		wp_d         = wp_q;
		rp_d         = rp_q;
		level_d      = level_q;
		seg_d        = seg_q;
		carried_d    = carried_q;
		half_d       = half_q;
		rem_d        = rem_q;
		budget_d     = budget_q;
		start_d      = start_q;
		pin_d        = pin_q;
		busy_d       = busy_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		emit         = 1'b0;
		res.pin      = pin_q;
		res.busy     = busy_q;
		res.done     = 1'b0;
		res.ovf      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_accept && req_type == REQ_PUSH) begin
					res.pin  = level_q;
					res.busy = (phase_q != PH_IDLE);
					emit     = 1'b1;
					if (!list_ready_q) begin
						if (wp_q == PTR_W'(LIST_DEPTH)) begin
							res.ovf = 1'b1;
						end else begin
							mem_we = 1'b1;
							wp_d   = wp_q + PTR_W'(1);
						end
						if (last_entry) begin
							list_ready_d = 1'b1;
						end
					end
				end else if (in_accept && phase_q == PH_IDLE) begin
					if (list_ready_q) begin
						seg_d   = cfg.init_level;
						level_d = cfg.init_level;
						rp_d    = '0;
						phase_d = PH_LIST;
						start_d = 1'b1;
						state_d = S_ADV;
					end else begin
						res.pin  = level_q;
						res.busy = 1'b0;
						emit     = 1'b1;
					end
				end
			end
			S_ADV, S_LOAD: begin
				if (state_q == S_ADV && rp_q < wp_q) begin
					mem_re  = 1'b1;
					rp_d    = rp_q + PTR_W'(1);
					state_d = S_LOAD;
				end else begin
					if (state_q == S_ADV) begin
						phase_d = PH_HOLD;
					end
					if (ld_ok) begin
						carried_d = ld_car;
						half_d    = cfg.half;
						rem_d     = ld_rem;
						budget_d  = ld_budget;
						level_d   = ld_level;
						start_d   = 1'b0;
						if (start_q) begin
							state_d = S_STEP;
						end else begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end else if (state_q == S_LOAD) begin
						// zero-length segment: toggle and fetch the next
						seg_d   = ~seg_q;
						level_d = ~seg_q;
						state_d = S_ADV;
					end else begin
						phase_d      = PH_IDLE;
						list_ready_d = 1'b0;
						wp_d         = '0;
						rp_d         = '0;
						start_d      = 1'b0;
						emit         = 1'b1;
						res.done     = 1'b1;
						if (start_q) begin
							res.pin  = level_q;
							res.busy = 1'b0;
						end
						state_d = S_IDLE;
					end
				end
			end
			S_STEP: begin
				// handled by the tick step below
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (run_step) begin
			pin_d    = level_q;
			busy_d   = 1'b1;
			res.pin  = level_q;
			res.busy = 1'b1;
			state_d  = S_IDLE;
			if (!rem_last) begin
				rem_d = rem_q - DUR_W'(1);
				emit  = 1'b1;
			end else if (carried_q && level_q) begin
				level_d  = 1'b0;
				rem_d    = {{(DUR_W - HALF_W){1'b0}}, half_q};
				budget_d = st_ge ? st_diff[DUR_W-1:0] : '0;
				emit     = 1'b1;
			end else if (carried_q && st_ge) begin
				level_d  = 1'b1;
				rem_d    = {{(DUR_W - HALF_W){1'b0}}, half_q};
				budget_d = st_diff[DUR_W-1:0];
				emit     = 1'b1;
			end else if (phase_q == PH_LIST) begin
				seg_d   = ~seg_q;
				level_d = ~seg_q;
				start_d = 1'b0;
				state_d = S_ADV;
			end else begin
				if (carried_q) begin
					level_d = 1'b1;
				end
				phase_d      = PH_IDLE;
				list_ready_d = 1'b0;
				wp_d         = '0;
				rp_d         = '0;
				emit         = 1'b1;
				res.done     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_IDLE;
			list_ready_q <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
			level_q      <= 1'b0;
			seg_q        <= 1'b0;
			carried_q    <= 1'b0;
			half_q       <= '0;
			rem_q        <= '0;
			budget_q     <= '0;
			start_q      <= 1'b0;
			pin_q        <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			list_ready_q <= list_ready_d;
			wp_q         <= wp_d;
			rp_q         <= rp_d;
			level_q      <= level_d;
			seg_q        <= seg_d;
			carried_q    <= carried_d;
			half_q       <= half_d;
			rem_q        <= rem_d;
			budget_q     <= budget_d;
			start_q      <= start_d;
			pin_q        <= pin_d;
			busy_q       <= busy_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/timed_pulse_train_with_carrier.sv -----
`default_nettype none

// Channel   Dir  Payload                                      Moves when
// in_ch     in   req_type, duration_us, last_entry            valid && ready
// out_ch    out  pin_level, busy_res, done_res, overflow      valid && ready
// cfg       in   cfg_idx, cfg_data                            cfg_we
//
// A push request is answered from the idle state, and so is a tick that stays inside
// the running interval or only flips the carrier half.
// A tick that starts playback or ends a list segment reads each store entry that it
// fetches (one store read port) in S_ADV and loads it in S_LOAD, and loads the hold
// when the list runs out; a start adds its first step in S_STEP.
// Zero-length segments toggle the level and fetch the next entry.
// Reset clears control state only; the duration store holds no reset value.
// in_ch.ready drops while the sequencer fetches or steps, and while the result
// register is full and not being drained.
module timed_pulse_train_with_carrier #(
	parameter int LIST_DEPTH = tptc_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	tptc_in_if.sink                                in_ch,
	tptc_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [tptc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tptc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tptc_pkg::*;

	localparam int AW = addr_w(LIST_DEPTH);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INIT_LEVEL:   cfg_q.init_level <= cfg_data[0];
				CFG_CARRIER_HALF: cfg_q.half       <= cfg_data[HALF_W-1:0];
				CFG_LAST_HOLD:    cfg_q.last_hold  <= cfg_data[DUR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer <-> store
	logic             play_idle;
	res_t             res;
	logic             emit;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [DUR_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [DUR_W-1:0] mem_rdata;
	logic             in_accept;

	// result register: a new request can enter while the last result drains
	logic out_valid_q;
	res_t out_res_q;

	assign in_ch.ready = play_idle && (!out_valid_q || out_ch.ready);
	assign in_accept   = in_ch.valid && in_ch.ready;

	tptc_play #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_play (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_accept  (in_accept),
		.req_type   (in_ch.req_type),
		.duration_us(in_ch.duration_us),
		.last_entry (in_ch.last_entry),
		.idle       (play_idle),
		.res        (res),
		.emit       (emit),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tptc_store #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			out_res_q   <= res;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.pin_level = out_res_q.pin;
	assign out_ch.busy_res  = out_res_q.busy;
	assign out_ch.done_res  = out_res_q.done;
	assign out_ch.overflow  = out_res_q.ovf;

endmodule

`default_nettype wire
